### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on clock and are
// disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every edge.
`define STE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition at one edge implies a consequence at the next edge.
`define STE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ste_pkg.sv
`default_nettype none

package ste_pkg;

   // Field widths of the request and response words
   localparam int OP_W     = 3;
   localparam int INDEX_W  = 8;
   localparam int NAME_W   = 64;
   localparam int FLAG_W   = 8;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
   localparam logic [OP_W-1:0] OP_READ    = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
   localparam logic [OP_W-1:0] OP_RESOLVE = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADIDX   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // Symbol flags: imported reference and exported (resolved) symbol
   localparam logic [FLAG_W-1:0] FLAG_I = 8'h49;
   localparam logic [FLAG_W-1:0] FLAG_E = 8'h45;

   // One table entry as stored in the memory
   typedef struct packed {
      logic [FLAG_W-1:0] flag;
      logic [NAME_W-1:0] name;
      logic [ADDR_W-1:0] address;
   } entry_type;

endpackage

`default_nettype wire

### rtl/ste_req_if.sv
`default_nettype none

interface ste_req_if;
   logic                          valid;
   logic                          ready;
   logic [ste_pkg::OP_W-1:0]      operation;
   logic [ste_pkg::INDEX_W-1:0]   entry_index;
   logic [ste_pkg::NAME_W-1:0]    key_name;
   logic [ste_pkg::FLAG_W-1:0]    key_flag;
   logic [ste_pkg::ADDR_W-1:0]    key_address;

   modport source (
      output valid, operation, entry_index, key_name, key_flag, key_address,
      input  ready
   );
   modport sink (
      input  valid, operation, entry_index, key_name, key_flag, key_address,
      output ready
   );
endinterface

interface ste_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ste_pkg::STATUS_W-1:0]  status;
   logic [ste_pkg::INDEX_W-1:0]   hit_index;
   logic [ste_pkg::FLAG_W-1:0]    hit_flag;
   logic [ste_pkg::NAME_W-1:0]    hit_name;
   logic [ste_pkg::ADDR_W-1:0]    hit_address;
   logic [ste_pkg::COUNT_W-1:0]   changed_count;
   logic [ste_pkg::COUNT_W-1:0]   entry_count;

   modport source (
      output valid, status, hit_index, hit_flag, hit_name, hit_address,
             changed_count, entry_count,
      input  ready
   );
   modport sink (
      input  valid, status, hit_index, hit_flag, hit_name, hit_address,
             changed_count, entry_count,
      output ready
   );
endinterface

`default_nettype wire

### rtl/symbol_table_engine.sv
// Symbol table engine: up to TABLE_DEPTH entries of {flag, name, address}.
// Request words come in on req_chan, one response word per request goes
// out on rsp_chan; both are valid/ready, a word moves when both are high.
// Operations: clear, append, read by index, search by name and flag, and
// resolve (every 'I' entry with the given name becomes 'E' with a new
// address). Names compare like strncmp over NAME_CHARS bytes.
// The table lives in one synchronous RAM with a registered read port.
// Path from an accepted request to the output register, by operation:
//   clear, append, bad read, unknown op : idle, done
//   read by index                       : idle, read wait, done
//   search, resolve                     : idle, scan over the entries, done
// Search and resolve walk the filled entries one per cycle through the
// RAM read port; resolve writes a hit back on the write port while the
// next entry is read. One request is in work at a time; req ready is high
// only while the engine is idle. The response sits in an output register:
// a new request is taken while an earlier response still waits; a finished
// result then holds until the output register frees up. Reset empties the
// table (entry count to zero) and drops any pending response; the RAM
// itself is not cleared.
`default_nettype none

`include "assert_macros.svh"

module symbol_table_engine #(
   parameter int TABLE_DEPTH = 256,
   parameter int NAME_CHARS  = 8
) (
   input  wire         clock,
   input  wire         reset,
   ste_req_if.sink     req_chan,
   ste_rsp_if.source   rsp_chan
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > ste_pkg::INDEX_W) ? CNT_W : ste_pkg::INDEX_W;
   localparam logic [ste_pkg::NAME_W-1:0] NAME_MASK =
      ste_pkg::NAME_W'((65'd1 << (8 * NAME_CHARS)) - 65'd1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_RDWAIT = 4'b0010,
      S_SCAN   = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   // strncmp-style compare of two masked names
   function automatic logic names_equal(input logic [ste_pkg::NAME_W-1:0] a,
                                        input logic [ste_pkg::NAME_W-1:0] b);
      logic eq;
      logic stop;
      eq   = 1'b1;
      stop = 1'b0;
      for (int k = 0; k < ste_pkg::NAME_W / 8; k++) begin
         if (!stop) begin
            if (a[8*k +: 8] != b[8*k +: 8]) begin
               eq   = 1'b0;
               stop = 1'b1;
            end else if (a[8*k +: 8] == 8'd0) begin
               stop = 1'b1;
            end
         end
      end
      return eq;
   endfunction

   // control state
   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic [CNT_W-1:0]             scan_ff, scan_in;
   logic                         pend_ff, pend_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // request held for the scan
   logic [IDX_W-1:0]             chk_idx_ff, chk_idx_in;
   logic [ste_pkg::OP_W-1:0]     op_ff, op_in;
   logic [ste_pkg::NAME_W-1:0]   key_name_ff, key_name_in;
   logic [ste_pkg::FLAG_W-1:0]   key_flag_ff, key_flag_in;
   logic [ste_pkg::ADDR_W-1:0]   key_addr_ff, key_addr_in;

   // result being built
   logic [ste_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ste_pkg::INDEX_W-1:0]  res_idx_ff, res_idx_in;
   logic [ste_pkg::FLAG_W-1:0]   res_flag_ff, res_flag_in;
   logic [ste_pkg::NAME_W-1:0]   res_name_ff, res_name_in;
   logic [ste_pkg::ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [CNT_W-1:0]             res_changed_ff, res_changed_in;

   // output register
   logic [ste_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ste_pkg::INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [ste_pkg::FLAG_W-1:0]   rsp_flag_ff, rsp_flag_in;
   logic [ste_pkg::NAME_W-1:0]   rsp_name_ff, rsp_name_in;
   logic [ste_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [ste_pkg::COUNT_W-1:0]  rsp_changed_ff, rsp_changed_in;
   logic [ste_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // table RAM
   ste_pkg::entry_type           mem [TABLE_DEPTH];
   ste_pkg::entry_type           rd_data_ff;
   ste_pkg::entry_type           mem_wdata;
   logic                         mem_we, mem_re;
   logic [IDX_W-1:0]             mem_waddr, mem_raddr;

   logic                         req_ready;
   logic                         req_accept;
   logic                         flag_ok;
   logic                         entry_hit;

   assign req_ready        = (state_ff == S_IDLE);
   assign req_accept       = req_chan.valid && req_ready;
   assign req_chan.ready   = req_ready;

   // match on the entry that came out of the RAM this cycle
   assign flag_ok   = (op_ff == ste_pkg::OP_SEARCH) ? (rd_data_ff.flag == key_flag_ff)
                                                    : (rd_data_ff.flag == ste_pkg::FLAG_I);
   assign entry_hit = pend_ff && flag_ok && names_equal(key_name_ff, rd_data_ff.name);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      scan_in        = scan_ff;
      pend_in        = pend_ff;
      chk_idx_in     = chk_idx_ff;
      op_in          = op_ff;
      key_name_in    = key_name_ff;
      key_flag_in    = key_flag_ff;
      key_addr_in    = key_addr_ff;
      res_status_in  = res_status_ff;
      res_idx_in     = res_idx_ff;
      res_flag_in    = res_flag_ff;
      res_name_in    = res_name_ff;
      res_addr_in    = res_addr_ff;
      res_changed_in = res_changed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_flag_in    = rsp_flag_ff;
      rsp_name_in    = rsp_name_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      mem_we         = 1'b0;
      mem_waddr      = fill_ff[IDX_W-1:0];
      mem_wdata      = '{flag: req_chan.key_flag,
                         name: req_chan.key_name & NAME_MASK,
                         address: req_chan.key_address};
      mem_re         = 1'b0;
      mem_raddr      = IDX_W'(req_chan.entry_index);

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in          = req_chan.operation;
               key_name_in    = req_chan.key_name & NAME_MASK;
               key_flag_in    = req_chan.key_flag;
               key_addr_in    = req_chan.key_address;
               res_status_in  = ste_pkg::ST_OK;
               res_idx_in     = '0;
               res_flag_in    = '0;
               res_name_in    = '0;
               res_addr_in    = '0;
               res_changed_in = '0;
               scan_in        = '0;
               pend_in        = 1'b0;
               state_in       = S_DONE;
               unique case (req_chan.operation)
                  ste_pkg::OP_CLEAR: begin
                     fill_in = '0;
                  end
                  ste_pkg::OP_APPEND: begin
                     if (fill_ff == FULL_COUNT) begin
                        res_status_in = ste_pkg::ST_FULL;
                     end else begin
                        mem_we      = 1'b1;
                        res_idx_in  = ste_pkg::INDEX_W'(fill_ff);
                        res_flag_in = req_chan.key_flag;
                        res_name_in = req_chan.key_name & NAME_MASK;
                        res_addr_in = req_chan.key_address;
                        fill_in     = fill_ff + 1'b1;
                     end
                  end
                  ste_pkg::OP_READ: begin
                     if (CMP_W'(req_chan.entry_index) < CMP_W'(fill_ff)) begin
                        mem_re     = 1'b1;
                        res_idx_in = req_chan.entry_index;
                        state_in   = S_RDWAIT;
                     end else begin
                        res_status_in = ste_pkg::ST_BADIDX;
                     end
                  end
                  ste_pkg::OP_SEARCH, ste_pkg::OP_RESOLVE: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_RDWAIT: begin
            res_flag_in = rd_data_ff.flag;
            res_name_in = rd_data_ff.name;
            res_addr_in = rd_data_ff.address;
            state_in    = S_DONE;
         end

         S_SCAN: begin
            // resolve: write the hit back while the next entry is read
            if (entry_hit && op_ff == ste_pkg::OP_RESOLVE) begin
               mem_we         = 1'b1;
               mem_waddr      = chk_idx_ff;
               mem_wdata      = '{flag: ste_pkg::FLAG_E,
                                  name: rd_data_ff.name,
                                  address: key_addr_ff};
               res_changed_in = res_changed_ff + 1'b1;
            end
            if (entry_hit && op_ff == ste_pkg::OP_SEARCH) begin
               res_idx_in  = ste_pkg::INDEX_W'(chk_idx_ff);
               res_flag_in = rd_data_ff.flag;
               res_name_in = rd_data_ff.name;
               res_addr_in = rd_data_ff.address;
               pend_in     = 1'b0;
               state_in    = S_DONE;
            end else if (scan_ff != fill_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = scan_ff[IDX_W-1:0];
               chk_idx_in = scan_ff[IDX_W-1:0];
               pend_in    = 1'b1;
               scan_in    = scan_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_DONE;
               if (op_ff == ste_pkg::OP_SEARCH) begin
                  res_status_in = ste_pkg::ST_NOTFOUND;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_status_in  = res_status_ff;
               rsp_idx_in     = res_idx_ff;
               rsp_flag_in    = res_flag_ff;
               rsp_name_in    = res_name_ff;
               rsp_addr_in    = res_addr_ff;
               rsp_changed_in = ste_pkg::COUNT_W'(res_changed_ff);
               rsp_count_in   = ste_pkg::COUNT_W'(fill_ff);
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff     <= chk_idx_in;
      op_ff          <= op_in;
      key_name_ff    <= key_name_in;
      key_flag_ff    <= key_flag_in;
      key_addr_ff    <= key_addr_in;
      res_status_ff  <= res_status_in;
      res_idx_ff     <= res_idx_in;
      res_flag_ff    <= res_flag_in;
      res_name_ff    <= res_name_in;
      res_addr_ff    <= res_addr_in;
      res_changed_ff <= res_changed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_flag_ff    <= rsp_flag_in;
      rsp_name_ff    <= rsp_name_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // table RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // response word
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.hit_index     = rsp_idx_ff;
   assign rsp_chan.hit_flag      = rsp_flag_ff;
   assign rsp_chan.hit_name      = rsp_name_ff;
   assign rsp_chan.hit_address   = rsp_addr_ff;
   assign rsp_chan.changed_count = rsp_changed_ff;
   assign rsp_chan.entry_count   = rsp_count_ff;

   // checks
   `STE_ASSERT(a_fill_bound, fill_ff <= FULL_COUNT, "entry count beyond table depth")
   `STE_ASSERT(a_scan_bound, (state_ff != S_SCAN) || (scan_ff <= fill_ff), "scan ran past the filled entries")
   `STE_ASSERT(a_write_state, !mem_we || (state_ff == S_IDLE) || (state_ff == S_SCAN), "RAM written outside append or resolve")
   `STE_ASSERT_NEXT(a_append_count, req_accept && (req_chan.operation == ste_pkg::OP_APPEND) && (fill_ff != FULL_COUNT), fill_ff == $past(fill_ff) + 1'b1, "append did not bump the entry count")

endmodule

`default_nettype wire
